[sv/gls_pkg.sv]
package gls_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int GRID_W    = 11;
	localparam int COEF_W    = 32;
	localparam int SAMPLE_W  = 32;
	localparam int LAP_W     = 48;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_DX_SQ   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_DY_SQ   = 2'd3;

	localparam logic [GRID_W-1:0] GRID_WIDTH_RST  = 11'd64;
	localparam logic [GRID_W-1:0] GRID_HEIGHT_RST = 11'd64;
	localparam logic [COEF_W-1:0] INV_SQ_RST      = 32'd65536;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	localparam int DIFF_W = 35;
	localparam int PROD_W = 52;
	localparam int TERM_W = 53;
	localparam int SUM_W  = 54;
	localparam int FRAC_W = 16;

	localparam logic signed [LAP_W-1:0] LAP_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [LAP_W-1:0] LAP_MIN = 48'sh8000_0000_0000;
	localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(LAP_MAX);
	localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(LAP_MIN);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] data;
		logic                       emit;
		logic                       left_ok;
		logic                       right_ok;
		logic                       up_ok;
		logic                       last;
	} item_t;

	typedef struct packed {
		logic [COEF_W-1:0] inv_dx_sq;
		logic [COEF_W-1:0] inv_dy_sq;
		logic              restart;
	} coef_t;

endpackage

[sv/gls_if.sv]
interface gls_item_if;
	logic                                valid;
	logic                                ready;
	logic                                command;
	logic signed [gls_pkg::SAMPLE_W-1:0] sample;

	modport source(output valid, command, sample, input ready);
	modport sink(input valid, command, sample, output ready);
	modport mon(input valid, ready, command, sample);
endinterface

interface gls_result_if;
	logic                             valid;
	logic                             ready;
	logic signed [gls_pkg::LAP_W-1:0] laplacian;
	logic                             last_of_frame;
	logic                             saturated;

	modport source(output valid, laplacian, last_of_frame, saturated, input ready);
	modport sink(input valid, laplacian, last_of_frame, saturated, output ready);
	modport mon(input valid, ready, laplacian, last_of_frame, saturated);
endinterface

interface gls_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [gls_pkg::CFG_IDX_W-1:0]   index;
	logic [gls_pkg::COEF_W-1:0]      data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
	modport mon(input valid, ready, index, data);
endinterface

[sv/grid_laplacian_stencil_unit.sv]
// Five-point Laplacian over one grid streamed in raster order, signed Q16.16.
// items: one beat per grid sample (command 0) or flush (command 1). Results
// trail input by one grid row; after the last sample send grid_width flush
// beats, each releasing one result of the bottom row. Samples after the frame
// is complete and flushes before it is complete are dropped with no result.
// results: laplacian saturated to 48 bits, saturated flag, last_of_frame on
// the final position, which also starts the next frame.
// cfg: register writes (grid_width, grid_height, inv_dx_sq, inv_dy_sq),
// always ready; writing a size restarts the frame. Write only while idle.
// Throughput: one item per cycle while results is not stalled, one beat through each back-end stage.
// Pipeline: the result released by an accepted beat passes through queue read
// with first line-store read, second line-store read, difference, multiply,
// term sum and saturate, in that order.
// Reset: counters cleared, registers return to 64, 64, 1.0, 1.0; no clearing
// pass. When results stalls, the back end holds and a four-entry queue keeps
// taking beats; items.ready drops once the queue fills.
module grid_laplacian_stencil_unit #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	gls_item_if.sink     items,
	gls_result_if.source results,
	gls_cfg_if.sink      cfg
);

	localparam int WW = $clog2(MAX_WIDTH + 1);

	logic           push, full, pop, empty;
	gls_pkg::item_t push_item, pop_item;
	logic [WW-1:0]  w_eff;
	gls_pkg::coef_t coef;

	gls_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .WW(WW)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.cfg       (cfg),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.w_eff     (w_eff),
		.coef      (coef)
	);

	gls_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (empty)
	);

	gls_back #(.MAX_WIDTH(MAX_WIDTH), .WW(WW)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.w_eff    (w_eff),
		.coef     (coef),
		.pop      (pop),
		.pop_item (pop_item),
		.empty    (empty),
		.results  (results)
	);

endmodule

[sv/gls_ram.sv]
module gls_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[sv/gls_front.sv]
module gls_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int WW         = $clog2(MAX_WIDTH + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	gls_item_if.sink       items,
	gls_cfg_if.sink        cfg,
	output logic           push,
	output gls_pkg::item_t push_item,
	input  logic           full,
	output logic [WW-1:0]  w_eff,
	output gls_pkg::coef_t coef
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic [gls_pkg::GRID_W-1:0] gw_q, gh_q;
	logic [gls_pkg::COEF_W-1:0] idx_q, idy_q;
	logic [HW-1:0]              h_eff;
	logic [CW-1:0]              ic_q, oc_q;
	logic [HW-1:0]              ir_q;
	logic [RW-1:0]              or_q;
	logic                       restart, accept, flush, complete, drop, emit, last;
	logic                       col_end, in_col_end;

	always_comb begin
		if (32'(gw_q) < 32'd2) begin
			w_eff = WW'(2);
		end else if (32'(gw_q) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(gw_q);
		end
		if (32'(gh_q) < 32'd2) begin
			h_eff = HW'(2);
		end else if (32'(gh_q) > 32'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(gh_q);
		end
	end

	assign cfg.ready = 1'b1;
	assign restart   = cfg.valid && (cfg.index == gls_pkg::CFG_GRID_WIDTH ||
		cfg.index == gls_pkg::CFG_GRID_HEIGHT);

	assign coef.inv_dx_sq = idx_q;
	assign coef.inv_dy_sq = idy_q;
	assign coef.restart   = restart;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q  <= gls_pkg::GRID_WIDTH_RST;
			gh_q  <= gls_pkg::GRID_HEIGHT_RST;
			idx_q <= gls_pkg::INV_SQ_RST;
			idy_q <= gls_pkg::INV_SQ_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				gls_pkg::CFG_GRID_WIDTH:  gw_q  <= cfg.data[gls_pkg::GRID_W-1:0];
				gls_pkg::CFG_GRID_HEIGHT: gh_q  <= cfg.data[gls_pkg::GRID_W-1:0];
				gls_pkg::CFG_INV_DX_SQ:   idx_q <= cfg.data;
				gls_pkg::CFG_INV_DY_SQ:   idy_q <= cfg.data;
			endcase
		end
	end

	assign items.ready = !full;
	assign accept      = items.valid && items.ready;
	assign flush       = items.command;
	assign complete    = ir_q >= h_eff;
	assign drop        = flush ? !complete : complete;
	assign emit        = flush || (ir_q != '0);
	assign col_end     = (WW'(oc_q) + WW'(1)) >= w_eff;
	assign in_col_end  = (WW'(ic_q) + WW'(1)) >= w_eff;
	assign last        = emit && col_end && ((HW'(or_q) + HW'(1)) >= h_eff);
	assign push        = accept && !drop;

	always_comb begin
		push_item.data     = flush ? '0 : items.sample;
		push_item.emit     = emit;
		push_item.left_ok  = oc_q != '0;
		push_item.right_ok = !col_end;
		push_item.up_ok    = or_q != '0;
		push_item.last     = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ic_q <= '0;
			ir_q <= '0;
			oc_q <= '0;
			or_q <= '0;
		end else if (restart) begin
			ic_q <= '0;
			ir_q <= '0;
			oc_q <= '0;
			or_q <= '0;
		end else if (push) begin
			if (last) begin
				ic_q <= '0;
				ir_q <= '0;
				oc_q <= '0;
				or_q <= '0;
			end else begin
				if (emit) begin
					if (col_end) begin
						oc_q <= '0;
						or_q <= or_q + RW'(1);
					end else begin
						oc_q <= oc_q + CW'(1);
					end
				end
				if (!flush) begin
					if (in_col_end) begin
						ic_q <= '0;
						ir_q <= ir_q + HW'(1);
					end else begin
						ic_q <= ic_q + CW'(1);
					end
				end
			end
		end
	end

endmodule

[sv/gls_queue.sv]
module gls_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  gls_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output gls_pkg::item_t pop_item,
	output logic           empty
);

	localparam int AW = gls_pkg::QUEUE_AW;

	gls_pkg::item_t mem_q [gls_pkg::QUEUE_DEPTH];
	logic [AW-1:0]  wr_q, rd_q;
	logic [AW:0]    cnt_q;

	assign full     = cnt_q == (AW + 1)'(gls_pkg::QUEUE_DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (AW + 1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (AW + 1)'(1);
			end
		end
	end

endmodule

[sv/gls_back.sv]
module gls_back #(
	parameter int MAX_WIDTH = 1024,
	parameter int WW        = $clog2(MAX_WIDTH + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [WW-1:0]  w_eff,
	input  gls_pkg::coef_t coef,
	output logic           pop,
	input  gls_pkg::item_t pop_item,
	input  logic           empty,
	gls_result_if.source   results
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int SW = gls_pkg::SAMPLE_W;
	localparam int DW = gls_pkg::DIFF_W;
	localparam int PW = gls_pkg::PROD_W;
	localparam int TW = gls_pkg::TERM_W;
	localparam int UW = gls_pkg::SUM_W;
	localparam int FW = gls_pkg::FRAC_W;

	logic                  adv, b_we;
	logic [AW-1:0]         pa_q, pb_q;
	logic [SW-1:0]         right_raw, up_raw;
	logic [SW-1:0]         c_q, l_q, lft, rgt, upv;
	logic signed [DW-1:0]  dx, dy;

	logic                  v_s1;
	gls_pkg::item_t        it_s1;

	logic                  e_s2, uok_s2, last_s2;
	logic signed [DW-1:0]  dx_s2;
	logic [SW-1:0]         c_s2, down_s2;

	logic                  e_s3, last_s3;
	logic signed [DW-1:0]  dx_s3, dy_s3;

	logic                  e_s4, last_s4;
	logic signed [PW-1:0]  pxh_s4, pxl_s4, pyh_s4, pyl_s4;

	logic                  e_s5, last_s5;
	logic signed [TW-1:0]  tx_s5, ty_s5;

	logic signed [UW-1:0]  sum;
	logic                  res_v_q, last_q, sat_q;
	logic signed [gls_pkg::LAP_W-1:0] lap_q;

	assign adv  = !res_v_q || results.ready;
	assign pop  = adv && !empty;
	assign b_we = adv && v_s1;

	gls_ram #(.WIDTH(SW), .DEPTH(MAX_WIDTH)) u_ram_right (
		.clk   (clk),
		.we    (pop),
		.waddr (pa_q),
		.wdata (pop_item.data),
		.re    (pop),
		.raddr (pa_q),
		.rdata (right_raw)
	);

	gls_ram #(.WIDTH(SW), .DEPTH(MAX_WIDTH)) u_ram_up (
		.clk   (clk),
		.we    (b_we),
		.waddr (pb_q),
		.wdata (c_q),
		.re    (b_we),
		.raddr (pb_q),
		.rdata (up_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pa_q <= '0;
			pb_q <= '0;
		end else if (coef.restart) begin
			pa_q <= '0;
			pb_q <= '0;
		end else begin
			if (pop) begin
				if (pop_item.last || (WW'(pa_q) + WW'(1)) >= (w_eff - WW'(1))) begin
					pa_q <= '0;
				end else begin
					pa_q <= pa_q + AW'(1);
				end
			end
			if (b_we) begin
				if (it_s1.last || (WW'(pb_q) + WW'(1)) >= w_eff) begin
					pb_q <= '0;
				end else begin
					pb_q <= pb_q + AW'(1);
				end
			end
		end
	end

	always_comb begin
		lft = it_s1.left_ok ? l_q : '0;
		rgt = it_s1.right_ok ? right_raw : '0;
		dx  = {{3{lft[SW-1]}}, lft} - {{2{c_q[SW-1]}}, c_q, 1'b0} + {{3{rgt[SW-1]}}, rgt};
		upv = uok_s2 ? up_raw : '0;
		dy  = {{3{upv[SW-1]}}, upv} - {{2{c_s2[SW-1]}}, c_s2, 1'b0}
			+ {{3{down_s2[SW-1]}}, down_s2};
		sum = UW'(tx_s5) + UW'(ty_s5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			e_s2    <= 1'b0;
			e_s3    <= 1'b0;
			e_s4    <= 1'b0;
			e_s5    <= 1'b0;
			res_v_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= pop;
			e_s2    <= v_s1 && it_s1.emit;
			e_s3    <= e_s2;
			e_s4    <= e_s3;
			e_s5    <= e_s4;
			res_v_q <= e_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (pop) begin
				it_s1 <= pop_item;
			end
			if (v_s1) begin
				c_q <= right_raw;
				l_q <= c_q;
			end
			dx_s2   <= dx;
			c_s2    <= c_q;
			down_s2 <= it_s1.data;
			uok_s2  <= it_s1.up_ok;
			last_s2 <= it_s1.last;

			dx_s3   <= dx_s2;
			dy_s3   <= dy;
			last_s3 <= last_s2;

			pxh_s4  <= PW'(dx_s3) * PW'($signed({1'b0, coef.inv_dx_sq[2*FW-1:FW]}));
			pxl_s4  <= PW'(dx_s3) * PW'($signed({1'b0, coef.inv_dx_sq[FW-1:0]}));
			pyh_s4  <= PW'(dy_s3) * PW'($signed({1'b0, coef.inv_dy_sq[2*FW-1:FW]}));
			pyl_s4  <= PW'(dy_s3) * PW'($signed({1'b0, coef.inv_dy_sq[FW-1:0]}));
			last_s4 <= last_s3;

			tx_s5   <= TW'(pxh_s4) + TW'(pxl_s4 >>> FW);
			ty_s5   <= TW'(pyh_s4) + TW'(pyl_s4 >>> FW);
			last_s5 <= last_s4;

			priority if (sum > gls_pkg::SUM_MAX) begin
				lap_q <= gls_pkg::LAP_MAX;
				sat_q <= 1'b1;
			end else if (sum < gls_pkg::SUM_MIN) begin
				lap_q <= gls_pkg::LAP_MIN;
				sat_q <= 1'b1;
			end else begin
				lap_q <= sum[gls_pkg::LAP_W-1:0];
				sat_q <= 1'b0;
			end
			last_q <= last_s5;
		end
	end

	assign results.valid         = res_v_q;
	assign results.laplacian     = lap_q;
	assign results.last_of_frame = last_q;
	assign results.saturated     = sat_q;

endmodule

[sv/gls_checker.sv]
module gls_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             res_valid,
	input logic                             res_ready,
	input logic signed [gls_pkg::LAP_W-1:0] laplacian,
	input logic                             last_of_frame,
	input logic                             saturated,
	input logic                             cfg_ready
);

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid
			&& $stable(laplacian) && $stable(saturated)
			&& $stable(last_of_frame))
		else $error("result beat changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && saturated |->
			laplacian == gls_pkg::LAP_MAX || laplacian == gls_pkg::LAP_MIN)
		else $error("saturated result not at a range limit");

	assert property (@(posedge clk)
		!arst_n |-> !res_valid)
		else $error("result valid during reset");

	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config port not ready");

endmodule

bind grid_laplacian_stencil_unit gls_checker u_gls_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (results.valid),
	.res_ready     (results.ready),
	.laplacian     (results.laplacian),
	.last_of_frame (results.last_of_frame),
	.saturated     (results.saturated),
	.cfg_ready     (cfg.ready)
);

[test/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  MAX_W       = 1024;
	localparam int  MAX_H       = 1024;
	localparam int  LINE_DEPTH  = 2 * MAX_W;
	localparam int  LINE_AW     = $clog2(LINE_DEPTH);
	localparam int  SETTLE      = 20;
	localparam int  CYCLE_LIMIT = 400000;
	localparam bit  CMD_SAMPLE  = 1'b0;
	localparam bit  CMD_FLUSH   = 1'b1;

	typedef struct {
		bit          cmd;
		logic [31:0] value;
	} grid_beat_t;

	typedef struct {
		logic [gls_pkg::LAP_W-1:0] value;
		bit                        last;
		bit                        clipped;
	} laplacian_t;

	logic clk = 1'b0;
	logic arst_n;

	gls_item_if   items_if();
	gls_result_if results_if();
	gls_cfg_if    cfg_if();

	grid_laplacian_stencil_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_if),
		.results(results_if),
		.cfg(cfg_if)
	);

	always #6 clk = ~clk;

	grid_beat_t grid_beats[$];
	laplacian_t pending_laplacians[$];
	grid_beat_t next_beat;
	laplacian_t want;

	int send_idle_pct = 30;
	int recv_idle_pct = 58;
	int error_count   = 0;
	int beat_count    = 0;
	int cycle_count   = 0;

	// stencil state mirror
	logic [31:0] line_mem [LINE_DEPTH];
	int          wr_ptr, in_col, in_row, out_col, out_row;
	logic [10:0] reg_width, reg_height;
	logic [31:0] coef_x, coef_y;

	function automatic int clamp_size(int v, int hi);
		return (v < 2) ? 2 : ((v > hi) ? hi : v);
	endfunction

	function automatic logic signed [71:0] stored(int back);
		return $signed(line_mem[LINE_AW'((wr_ptr + LINE_DEPTH - back) % LINE_DEPTH)]);
	endfunction

	function automatic logic signed [71:0] scaled(logic signed [71:0] d, logic [31:0] c);
		logic signed [71:0] cs;
		cs = {40'd0, c};
		return (d * cs) >>> gls_pkg::FRAC_W;
	endfunction

	function automatic void restart_frame();
		wr_ptr  = 0;
		in_col  = 0;
		in_row  = 0;
		out_col = 0;
		out_row = 0;
	endfunction

	function automatic void advance_stencil(bit cmd, logic [31:0] smp);
		int                 w, h;
		bit                 emit;
		logic [31:0]        raw;
		logic signed [71:0] center, left_n, right_n, up_n, down_n, total;
		laplacian_t         res;
		w      = clamp_size(int'(reg_width), MAX_W);
		h      = clamp_size(int'(reg_height), MAX_H);
		raw    = smp;
		down_n = '0;
		if (cmd == CMD_FLUSH) begin
			if (in_row < h)
				return;
			emit = 1'b1;
			raw  = '0;
		end else begin
			if (in_row >= h)
				return;
			emit   = (in_row >= 1);
			down_n = $signed(smp);
		end
		if (emit) begin
			center  = stored(w);
			left_n  = (out_col > 0) ? stored(w + 1) : '0;
			right_n = (out_col + 1 < w) ? stored(w - 1) : '0;
			up_n    = (out_row > 0) ? stored(2 * w) : '0;
			total   = scaled(left_n - 2 * center + right_n, coef_x)
			        + scaled(up_n - 2 * center + down_n, coef_y);
			res.clipped = 1'b0;
			if (total > gls_pkg::LAP_MAX) begin
				total       = gls_pkg::LAP_MAX;
				res.clipped = 1'b1;
			end
			if (total < gls_pkg::LAP_MIN) begin
				total       = gls_pkg::LAP_MIN;
				res.clipped = 1'b1;
			end
			res.value = total[gls_pkg::LAP_W-1:0];
			res.last  = (out_row + 1 >= h) && (out_col + 1 >= w);
			pending_laplacians.push_back(res);
			if (res.last) begin
				restart_frame();
				return;
			end
			if (out_col + 1 >= w) begin
				out_col = 0;
				out_row++;
			end else begin
				out_col++;
			end
		end
		line_mem[LINE_AW'(wr_ptr)] = raw;
		wr_ptr = (wr_ptr + 1) % LINE_DEPTH;
		if (cmd == CMD_SAMPLE) begin
			if (in_col + 1 >= w) begin
				in_col = 0;
				in_row++;
			end else begin
				in_col++;
			end
		end
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items_if.valid   <= 1'b0;
			items_if.command <= CMD_SAMPLE;
			items_if.sample  <= '0;
		end else begin
			if (items_if.valid && items_if.ready)
				advance_stencil(items_if.command, items_if.sample);
			if (!items_if.valid || items_if.ready) begin
				if (grid_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_beat = grid_beats.pop_front();
					items_if.valid   <= 1'b1;
					items_if.command <= next_beat.cmd;
					items_if.sample  <= next_beat.value;
				end else begin
					items_if.valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_if.ready <= 1'b0;
		end else begin
			results_if.ready <= ($urandom_range(99) >= recv_idle_pct);
			if (results_if.valid && results_if.ready) begin
				if (pending_laplacians.size() == 0) begin
					$error("unexpected result beat: laplacian %0d",
						$signed(results_if.laplacian));
					error_count++;
				end else begin
					want = pending_laplacians.pop_front();
					if (results_if.laplacian !== want.value) begin
						$error("laplacian: expected %0d, got %0d",
							$signed(want.value), $signed(results_if.laplacian));
						error_count++;
					end
					if (results_if.last_of_frame !== want.last) begin
						$error("last_of_frame: expected %0b, got %0b",
							want.last, results_if.last_of_frame);
						error_count++;
					end
					if (results_if.saturated !== want.clipped) begin
						$error("saturated: expected %0b, got %0b",
							want.clipped, results_if.saturated);
						error_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic void push_beat(bit cmd, logic [31:0] value);
		grid_beat_t b;
		b.cmd   = cmd;
		b.value = value;
		grid_beats.push_back(b);
		beat_count++;
	endfunction

	function automatic logic [31:0] pick_sample();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3: return $urandom_range(1 << 20) - (1 << 19);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_coef();
		case ($urandom_range(7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return gls_pkg::INV_SQ_RST;
			3: return $urandom_range(262143);
			default: return $urandom;
		endcase
	endfunction

	function automatic void push_frame(int w, int h, int stop);
		for (int i = 0; i < stop; i++) begin
			if ($urandom_range(24) == 0)
				push_beat(CMD_FLUSH, $urandom);
			push_beat(CMD_SAMPLE, pick_sample());
		end
		if (stop < w * h)
			return;
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(1, 2)) push_beat(CMD_SAMPLE, pick_sample());
		for (int i = 0; i < w; i++)
			push_beat(CMD_FLUSH, $urandom);
		if ($urandom_range(7) == 0)
			push_beat(CMD_FLUSH, $urandom);
	endfunction

	task automatic drain();
		do @(negedge clk);
		while (grid_beats.size() != 0 || items_if.valid || pending_laplacians.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(logic [gls_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		do @(posedge clk);
		while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		case (idx)
			gls_pkg::CFG_GRID_WIDTH: begin
				reg_width = value[10:0];
				restart_frame();
			end
			gls_pkg::CFG_GRID_HEIGHT: begin
				reg_height = value[10:0];
				restart_frame();
			end
			gls_pkg::CFG_INV_DX_SQ: coef_x = value;
			gls_pkg::CFG_INV_DY_SQ: coef_y = value;
		endcase
	endtask

	task automatic run_phase(logic [31:0] w_raw, logic [31:0] h_raw, int frames, int cut);
		int w, h;
		w = clamp_size(int'(w_raw[10:0]), MAX_W);
		h = clamp_size(int'(h_raw[10:0]), MAX_H);
		write_reg(gls_pkg::CFG_GRID_WIDTH, w_raw);
		write_reg(gls_pkg::CFG_GRID_HEIGHT, h_raw);
		write_reg(gls_pkg::CFG_INV_DX_SQ, pick_coef());
		write_reg(gls_pkg::CFG_INV_DY_SQ, pick_coef());
		for (int f = 0; f < frames; f++)
			push_frame(w, h, (f == frames - 1 && cut > 0) ? cut : w * h);
		drain();
	endtask

	initial begin
		int w, h, frames, cut;
		bit big_done;
		big_done         = 1'b0;
		arst_n           = 1'b0;
		items_if.valid   = 1'b0;
		items_if.command = CMD_SAMPLE;
		items_if.sample  = '0;
		results_if.ready = 1'b0;
		cfg_if.valid     = 1'b0;
		cfg_if.index     = gls_pkg::CFG_GRID_WIDTH;
		cfg_if.data      = '0;
		for (int i = 0; i < LINE_DEPTH; i++)
			line_mem[LINE_AW'(i)] = '0;
		restart_frame();
		reg_width  = gls_pkg::GRID_WIDTH_RST;
		reg_height = gls_pkg::GRID_HEIGHT_RST;
		coef_x     = gls_pkg::INV_SQ_RST;
		coef_y     = gls_pkg::INV_SQ_RST;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// smallest grid, largest coefficients, extreme samples
		write_reg(gls_pkg::CFG_GRID_WIDTH, 32'd0);
		write_reg(gls_pkg::CFG_GRID_HEIGHT, 32'd1);
		write_reg(gls_pkg::CFG_INV_DX_SQ, 32'hFFFF_FFFF);
		write_reg(gls_pkg::CFG_INV_DY_SQ, 32'hFFFF_FFFF);
		push_beat(CMD_FLUSH, 32'hFFFF_FFFF);
		push_beat(CMD_SAMPLE, 32'h7FFF_FFFF);
		push_beat(CMD_SAMPLE, 32'h8000_0000);
		push_beat(CMD_SAMPLE, 32'h8000_0000);
		push_beat(CMD_SAMPLE, 32'h7FFF_FFFF);
		push_beat(CMD_SAMPLE, 32'h1234_5678);
		push_beat(CMD_FLUSH, 32'h0);
		push_beat(CMD_FLUSH, 32'h0);
		push_beat(CMD_SAMPLE, 32'h0000_0000);
		push_beat(CMD_SAMPLE, 32'hFFFF_FFFF);
		push_beat(CMD_SAMPLE, 32'h0000_0001);
		push_beat(CMD_SAMPLE, 32'h8000_0000);
		push_beat(CMD_FLUSH, 32'h0);
		push_beat(CMD_FLUSH, 32'h0);
		push_beat(CMD_FLUSH, 32'h0);
		drain();
		// tiny coefficients round negative terms toward minus infinity
		write_reg(gls_pkg::CFG_INV_DX_SQ, 32'd1);
		write_reg(gls_pkg::CFG_INV_DY_SQ, 32'd65535);
		push_beat(CMD_SAMPLE, 32'hFFFF_FFFF);
		push_beat(CMD_SAMPLE, 32'h0000_0003);
		push_beat(CMD_SAMPLE, 32'hFFFF_FFFD);
		push_beat(CMD_SAMPLE, 32'h0000_0001);
		push_beat(CMD_FLUSH, 32'h0);
		push_beat(CMD_FLUSH, 32'h0);
		drain();

		while (beat_count < 700) begin
			if (beat_count >= 480) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (beat_count >= 250) begin
				send_idle_pct = 58;
				recv_idle_pct = 30;
			end
			w      = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 8);
			h      = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 6);
			frames = $urandom_range(1, 3);
			cut    = ($urandom_range(5) == 0) ? $urandom_range(1, clamp_size(w, MAX_W)
				* clamp_size(h, MAX_H) - 1) : 0;
			run_phase({21'($urandom_range(2097151)), 11'(w)},
				{21'($urandom_range(2097151)), 11'(h)}, frames, cut);
			if (!big_done && beat_count >= 400) begin
				big_done = 1'b1;
				// widest row, clamped from the top of the register
				run_phase(32'd2047, 32'd2, 1, 24);
				// tallest grid, clamped, only the first rows sent
				run_phase(32'd2, 32'd2047, 1, 12);
				run_phase(32'd1024, 32'd1024, 1, 40);
			end
		end
		drain();
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[files.f]
sv/gls_pkg.sv
sv/gls_if.sv
sv/gls_ram.sv
sv/gls_front.sv
sv/gls_queue.sv
sv/gls_back.sv
sv/grid_laplacian_stencil_unit.sv
sv/gls_checker.sv
test/tb_top.sv
